### src/ils_pkg.sv
// shared types, constants and codes for the indexed list store
`default_nettype none

package ils_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int POS_W    = 9;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_READ     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_POS  = 3'd3,
    OP_DELETE   = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    RES_DONE  = 2'd0,
    RES_RANGE = 2'd1,
    RES_FULL  = 2'd2
  } res_code_e;

  typedef enum logic [1:0] {
    SEL_ZERO = 2'd0,
    SEL_NEG1 = 2'd1,
    SEL_MEM  = 2'd2
  } sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT,
    ST_DRAIN,
    ST_WRITE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      rd_pos;
    logic      shift_start;
    logic      shift_step;
    logic      ins_write;
    logic      cnt_dec;
    logic      res_set;
    res_code_e res_code;
    sel_e      res_sel;
    logic      out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            pos_lt_cnt;
    logic            ep_le_cnt;
    logic            ep_eq_cnt;
    logic            full;
    logic            del_last;
    logic            shift_last;
    logic            out_free;
  } dp_flags_t;

endpackage

`default_nettype wire

### src/indexed_list_store_core.sv
// top level of the indexed list store: controller plus datapath
//
//   channel  dir  handshake                 beat
//   in       in   in_valid_i / in_stall_o   in_beat_t  (opcode, position, data_value)
//   out      out  out_valid_o / out_stall_i out_beat_t (read_value, status)
//
// controller states per command, from accept to result loaded into the output register:
//   read, or any refused / unknown command: decode, result
//   insert: decode, shift, drain, write, result when entries move;
//           decode, write, result when appending at the tail
//   delete: decode, shift, drain, result when entries move; decode, result when removing the last entry
// the entry memory moves one entry per cycle (one read, one write port),
// which sets the insert and delete time
// reset clears the count and all control state; no memory clearing pass
// a new command is taken while the previous result waits on out_stall_i;
// its result is held back until the output register is free
`default_nettype none

module indexed_list_store_core import ils_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  in_beat_t   in_beat_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output out_beat_t  out_beat_o
);

  // command and status between the two halves
  dp_cmd_t   dp_cmd;
  dp_flags_t dp_flags;

  // controller: one command at a time, idle state takes the next beat
  ils_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .flags_i    (dp_flags),
    .cmd_o      (dp_cmd)
  );

  // datapath: memory, count, shift pointer, output register
  ils_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .cmd_i       (dp_cmd),
    .flags_o     (dp_flags),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire

### src/ils_dpath.sv
// datapath: entry memory, count, shift pointer and result register
`default_nettype none

module ils_dpath import ils_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  in_beat_t   in_beat_i,
  input  dp_cmd_t    cmd_i,
  output dp_flags_t  flags_o,
  input  wire        out_stall_i,
  output logic       out_valid_o,
  output out_beat_t  out_beat_o
);

  logic [DATA_W-1:0] mem [CAPACITY];

  in_beat_t          cmd_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [ADDR_W-1:0] wr_addr_q;
  logic              wr_pend_q;
  logic [DATA_W-1:0] rdata_q;
  res_code_e         res_code_q;
  sel_e              res_sel_q;
  logic              out_valid_q;
  out_beat_t         out_q;

  logic [CMP_W-1:0]  pos_x, cnt_x, ep_x;
  logic [ADDR_W-1:0] ep_addr, last_addr, end_addr;
  logic              is_del;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] res_value;

  assign pos_x  = CMP_W'(cmd_q.position);
  assign cnt_x  = CMP_W'(count_q);
  assign is_del = (cmd_q.opcode == OP_DELETE);

  // effective insert position
  always_comb begin
    case (op_e'(cmd_q.opcode))
      OP_INS_HEAD: ep_x = '0;
      OP_INS_TAIL: ep_x = cnt_x;
      default:     ep_x = pos_x;
    endcase
  end

  assign ep_addr   = ep_x[ADDR_W-1:0];
  assign last_addr = ADDR_W'(count_q - CNT_W'(1));
  assign end_addr  = is_del ? last_addr : ep_addr;

  assign flags_o.opcode     = cmd_q.opcode;
  assign flags_o.pos_lt_cnt = (pos_x < cnt_x);
  assign flags_o.ep_le_cnt  = (ep_x <= cnt_x);
  assign flags_o.ep_eq_cnt  = (ep_x == cnt_x);
  assign flags_o.full       = (count_q == CNT_W'(CAPACITY));
  assign flags_o.del_last   = ((pos_x + CMP_W'(1)) == cnt_x);
  assign flags_o.shift_last = (rd_ptr_q == end_addr);
  assign flags_o.out_free   = !out_valid_q || !out_stall_i;

  // shift pointer: insert walks down from the tail, delete walks up
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    if (cmd_i.shift_start) begin
      rd_ptr_d = is_del ? ADDR_W'(cmd_q.position + POS_W'(1)) : last_addr;
    end else if (cmd_i.shift_step) begin
      rd_ptr_d = is_del ? rd_ptr_q + ADDR_W'(1) : rd_ptr_q - ADDR_W'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins_write) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // one read and one write port
  assign mem_re    = cmd_i.rd_pos || cmd_i.shift_step;
  assign mem_raddr = cmd_i.rd_pos ? cmd_q.position[ADDR_W-1:0] : rd_ptr_q;
  assign mem_we    = cmd_i.ins_write || wr_pend_q;
  assign mem_waddr = cmd_i.ins_write ? ep_addr : wr_addr_q;
  assign mem_wdata = cmd_i.ins_write ? cmd_q.data_value : rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_comb begin
    case (res_sel_q)
      SEL_MEM:  res_value = rdata_q;
      SEL_NEG1: res_value = '1;
      default:  res_value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      wr_pend_q <= cmd_i.shift_step;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_beat_i;
    end
    rd_ptr_q <= rd_ptr_d;
    if (cmd_i.shift_step) begin
      wr_addr_q <= is_del ? rd_ptr_q - ADDR_W'(1) : rd_ptr_q + ADDR_W'(1);
    end
    if (cmd_i.res_set) begin
      res_code_q <= cmd_i.res_code;
      res_sel_q  <= cmd_i.res_sel;
    end
    if (cmd_i.out_load) begin
      out_q.read_value <= res_value;
      out_q.status     <= STAT_W'(res_code_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

`default_nettype wire

### src/ils_ctrl.sv
// controller: sequences decode, shift, drain, write and result per command
`default_nettype none

module ils_ctrl import ils_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  dp_flags_t  flags_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_code = RES_DONE;
    cmd_o.res_sel  = SEL_ZERO;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_d       = ST_RESP;
        cmd_o.res_set = 1'b1;
        case (op_e'(flags_i.opcode))
          OP_READ: begin
            if (flags_i.pos_lt_cnt) begin
              cmd_o.rd_pos  = 1'b1;
              cmd_o.res_sel = SEL_MEM;
            end else begin
              cmd_o.res_code = RES_RANGE;
              cmd_o.res_sel  = SEL_NEG1;
            end
          end
          OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
            if (!flags_i.ep_le_cnt) begin
              cmd_o.res_code = RES_RANGE;
            end else if (flags_i.full) begin
              cmd_o.res_code = RES_FULL;
            end else if (flags_i.ep_eq_cnt) begin
              state_d = ST_WRITE;
            end else begin
              cmd_o.shift_start = 1'b1;
              state_d           = ST_SHIFT;
            end
          end
          OP_DELETE: begin
            if (!flags_i.pos_lt_cnt) begin
              cmd_o.res_code = RES_RANGE;
            end else if (flags_i.del_last) begin
              cmd_o.cnt_dec = 1'b1;
            end else begin
              cmd_o.shift_start = 1'b1;
              state_d           = ST_SHIFT;
            end
          end
          default: ;
        endcase
      end

      ST_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (flags_i.shift_last) begin
          state_d = ST_DRAIN;
        end
      end

      // last moved entry is written this cycle
      ST_DRAIN: begin
        if (flags_i.opcode == OP_DELETE) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.res_set = 1'b1;
          state_d       = ST_RESP;
        end else begin
          state_d = ST_WRITE;
        end
      end

      ST_WRITE: begin
        cmd_o.ins_write = 1'b1;
        cmd_o.res_set   = 1'b1;
        state_d         = ST_RESP;
      end

      ST_RESP: begin
        if (flags_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### verif/testbench.sv
// self-checking testbench for the indexed list store: directed and random commands
`timescale 1ns / 100ps

module testbench;
  import ils_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int ITEM_TOTAL     = 1050;
  localparam int CALM_FROM      = 900;   // no idling on either side from here on
  localparam int HOLD_AT        = 450;   // beat count at which the long output hold starts
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = CAPACITY + 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_beat   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_beat_t out_beat;

  indexed_list_store_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // command stream and the responses still owed by the block
  in_beat_t  cmd_q[$];
  out_beat_t resp_q[$];

  // expected list contents, updated as commands are accepted
  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  int list_count = 0;

  // entry count as seen by the command generator, used only to aim positions
  int gen_count = 0;

  int   in_accepted  = 0;
  int   mismatches   = 0;
  int   stuck_cycles = 0;
  logic in_taken     = 1'b0;
  int   in_gap       = 0;
  int   stall_left   = 0;
  int   hold_left    = 0;
  logic hold_done    = 1'b0;

  // idling pauses in stretches and stops for the tail of the run
  wire calm = (in_accepted >= CALM_FROM) || ((in_accepted % 200) >= 160);

  // ---------------------------------------------------------------------------
  // list behavior
  // ---------------------------------------------------------------------------

  // insert before pos; range is checked ahead of the full condition
  function automatic res_code_e list_insert(int pos, logic signed [DATA_W-1:0] val);
    int i;
    if (pos > list_count) return RES_RANGE;
    if (list_count >= CAPACITY) return RES_FULL;
    for (i = list_count; i > pos; i--) list_mem[i] = list_mem[i-1];
    list_mem[pos] = val;
    list_count++;
    return RES_DONE;
  endfunction

  function automatic out_beat_t list_response(in_beat_t cmd);
    out_beat_t r;
    int i;
    r.read_value = '0;
    r.status     = RES_DONE;
    case (cmd.opcode)
      OP_READ: begin
        if (cmd.position < list_count) begin
          r.read_value = list_mem[cmd.position];
        end else begin
          r.read_value = -1;
          r.status     = RES_RANGE;
        end
      end
      OP_INS_HEAD: r.status = list_insert(0, cmd.data_value);
      OP_INS_TAIL: r.status = list_insert(list_count, cmd.data_value);
      OP_INS_POS:  r.status = list_insert(int'(cmd.position), cmd.data_value);
      OP_DELETE: begin
        if (cmd.position < list_count) begin
          for (i = int'(cmd.position); i < list_count - 1; i++) list_mem[i] = list_mem[i+1];
          list_count--;
        end else begin
          r.status = RES_RANGE;
        end
      end
      default: ;  // unknown opcodes leave the list alone and report done
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // command generation
  // ---------------------------------------------------------------------------

  task automatic add_cmd(logic [OP_W-1:0] op, int pos, logic [DATA_W-1:0] val);
    in_beat_t b;
    b.opcode     = op;
    b.position   = pos[POS_W-1:0];
    b.data_value = val;
    cmd_q.push_back(b);
    case (op)
      OP_INS_HEAD, OP_INS_TAIL: if (gen_count < CAPACITY) gen_count++;
      OP_INS_POS: if (pos <= gen_count && gen_count < CAPACITY) gen_count++;
      OP_DELETE:  if (pos < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  // mostly legal positions; grow_pct / shrink_pct steer the entry count
  task automatic add_random_cmd(int grow_pct, int shrink_pct);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       add_cmd(OP_INS_HEAD, $urandom_range(0, 511), $urandom);
        1:       add_cmd(OP_INS_TAIL, $urandom_range(0, 511), $urandom);
        default: add_cmd(OP_INS_POS, $urandom_range(0, gen_count), $urandom);
      endcase
    end else if (pick < grow_pct + shrink_pct) begin
      add_cmd(OP_DELETE, (gen_count > 0) ? $urandom_range(0, gen_count - 1) : 0, $urandom);
    end else if (pick < 95) begin
      add_cmd(OP_READ, (gen_count > 0) ? $urandom_range(0, gen_count - 1)
                                       : $urandom_range(0, 511), $urandom);
    end else begin
      add_cmd(OP_W'($urandom_range(0, 7)), $urandom_range(0, 511), $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // input driver: one beat at a time, new values only at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (cmd_q.size() > 0) begin
        in_beat  <= cmd_q.pop_front();
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output stall: short random bursts plus one long hold so the block backs up
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && in_accepted >= HOLD_AT) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
        hold_done <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: check results first, then book the command taken at this edge
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(string what, out_beat_t want, out_beat_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s: expected value %0d status %0d, got value %0d status %0d",
               $time, what, want.read_value, want.status, got.read_value, got.status);
  endtask

  always @(posedge clk) begin : monitor
    out_beat_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (resp_q.size() == 0) begin
          note_mismatch("result with none outstanding", '0, out_beat);
        end else begin
          want = resp_q.pop_front();
          if (out_beat.read_value !== want.read_value || out_beat.status !== want.status)
            note_mismatch("result mismatch", want, out_beat);
        end
      end
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        resp_q.push_back(list_response(in_beat));
        in_accepted <= in_accepted + 1;
      end
    end
  end

  // watchdog: cycles without a beat on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int i;

    // empty list: every position used here is out of range
    add_cmd(OP_READ, 0, $urandom);
    add_cmd(OP_READ, 511, $urandom);
    add_cmd(OP_DELETE, 0, $urandom);
    add_cmd(OP_INS_POS, 1, $urandom);
    add_cmd(OP_INS_POS, 511, $urandom);
    // build five entries with extreme values through every insert kind
    add_cmd(OP_INS_HEAD, 0, 32'h7FFF_FFFF);
    add_cmd(OP_INS_TAIL, 511, 32'h8000_0000);
    add_cmd(OP_INS_POS, 1, 32'hFFFF_FFFF);
    add_cmd(OP_INS_POS, 3, 32'h0000_0000);   // position equal to count appends
    add_cmd(OP_INS_POS, 0, 32'h5A5A_A5A5);
    for (i = 0; i <= 5; i++) add_cmd(OP_READ, i, $urandom);
    // unknown opcodes with all-ones and all-zeros fields
    add_cmd(3'd5, 511, 32'hFFFF_FFFF);
    add_cmd(3'd6, 511, 32'hFFFF_FFFF);
    add_cmd(3'd7, 0, 32'h0000_0000);
    // middle, last, past-the-end and head deletes
    add_cmd(OP_DELETE, 2, $urandom);
    add_cmd(OP_DELETE, 3, $urandom);
    add_cmd(OP_DELETE, 3, $urandom);
    add_cmd(OP_DELETE, 0, $urandom);
    add_cmd(OP_READ, 0, $urandom);
    add_cmd(OP_READ, 1, $urandom);

    // fill the list up to capacity
    while (gen_count < CAPACITY) add_random_cmd(88, 4);

    // full list: refused inserts, range before full, reads at the top end, then deletes and re-inserts
    add_cmd(OP_INS_HEAD, 0, $urandom);
    add_cmd(OP_INS_TAIL, 0, $urandom);
    add_cmd(OP_INS_POS, CAPACITY, $urandom);
    add_cmd(OP_INS_POS, CAPACITY + 1, $urandom);
    add_cmd(OP_INS_POS, 0, $urandom);
    add_cmd(OP_READ, CAPACITY - 1, $urandom);
    add_cmd(OP_READ, CAPACITY, $urandom);
    add_cmd(OP_DELETE, CAPACITY, $urandom);
    add_cmd(OP_DELETE, CAPACITY - 1, $urandom);
    add_cmd(OP_INS_POS, CAPACITY - 1, $urandom);
    add_cmd(OP_INS_TAIL, 0, $urandom);
    add_cmd(OP_DELETE, 0, $urandom);
    add_cmd(OP_INS_HEAD, 0, $urandom);
    add_cmd(OP_READ, 0, $urandom);

    // drain back down, then noise, then a mixed walk
    while (gen_count > 4) add_random_cmd(4, 88);
    for (i = 0; i < 80; i++)
      add_cmd(OP_W'($urandom_range(0, 7)), $urandom_range(0, 511), $urandom);
    while (cmd_q.size() < ITEM_TOTAL) add_random_cmd(45, 40);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() > 0 || in_valid || resp_q.size() > 0) @(posedge clk);
    // a stray late result would still be caught here
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### indexed_list_store_core.f
src/ils_pkg.sv
src/ils_dpath.sv
src/ils_ctrl.sv
src/indexed_list_store_core.sv
verif/testbench.sv
